// ===== hw/rtl/vau_pkg.sv =====
`default_nettype none

package vau_pkg;

  localparam int FRAC_BITS = 16;
  // Dividend width: a 32-bit magnitude shifted up by the fraction bits.
  localparam int DW = 32 + FRAC_BITS;
  // One root bit per stage for a 64-bit radicand.
  localparam int SQ_STAGES = 32;
  localparam int REM_W = 36;

  typedef enum logic [3:0] {
    FN_ADD   = 4'd0,
    FN_SUB   = 4'd1,
    FN_SCALE = 4'd2,
    FN_DIV   = 4'd3,
    FN_CMUL  = 4'd4,
    FN_NEG   = 4'd5,
    FN_DOT   = 4'd6,
    FN_MAG   = 4'd7,
    FN_NORM  = 4'd8
  } func_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic signed [65:0] MAX_V = 66'sd2147483647;
  localparam logic signed [65:0] MIN_V = -66'sd2147483648;
  localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [31:0] val;
    logic        hit;
  } sat_t;

  // Fields that ride along the whole pipeline.
  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rs;
    logic [1:0]  st;
    logic [31:0] ax_mag;
    logic [31:0] ay_mag;
    logic        ax_neg;
    logic        ay_neg;
    logic        s_neg;
    logic [31:0] s_mag;
  } carry_t;

  typedef struct packed {
    carry_t            c;
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [32:0] lx;
    logic signed [32:0] ly;
  } s1_t;

  typedef struct packed {
    carry_t             c;
    logic [63:0]        n;
    logic [REM_W-1:0]   rem;
    logic [31:0]        root;
  } sq_t;

  typedef struct packed {
    carry_t      c;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [31:0] dvs;
    logic [31:0] remx;
    logic [31:0] remy;
  } dv_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > MAX_V) begin
      r.val = 32'h7FFF_FFFF;
      r.hit = 1'b1;
    end else if (v < MIN_V) begin
      r.val = 32'h8000_0000;
      r.hit = 1'b1;
    end else begin
      r.val = v[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vec2_arithmetic_unit.sv =====
// 2D vector arithmetic unit in signed Q16.16: add, subtract, scale, divide by scalar,
// componentwise multiply, negate, dot product, magnitude and normalize. It accepts one
// item every cycle unless the result channel stalls, and returns one result per item,
// in order, through a multiplier stage, a round and saturate stage, a 32-stage square
// root that yields one root bit per stage, a restoring divider that yields one quotient
// bit per stage for both components, and an output register.
// Every item passes through all stages; a stall on the result channel holds the whole
// pipeline. Out-of-range results clamp with status 1; division by zero or normalizing
// a zero vector returns zeros with status 2.
`default_nettype none

module vec2_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_scalar_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_x,
  output logic signed [31:0] out_result_y,
  output logic signed [31:0] out_result_scalar,
  output logic [1:0]         out_status
);

  logic en;

  vau_pkg::s1_t s1_nxt, s1_r;
  logic         s1_v_r;
  vau_pkg::sq_t s2_nxt, s2_r;
  logic         s2_v_r;
  vau_pkg::sq_t sq_r [vau_pkg::SQ_STAGES];
  logic         sq_v_r [vau_pkg::SQ_STAGES];
  vau_pkg::dv_t dv_entry;
  vau_pkg::dv_t dv_r [vau_pkg::DW];
  logic         dv_v_r [vau_pkg::DW];

  logic               out_v_r;
  logic [31:0]        ox_r, oy_r, os_r;
  logic [31:0]        ox_nxt, oy_nxt, os_nxt;
  logic [1:0]         ost_r, ost_nxt;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  function automatic vau_pkg::sq_t sq_step(input vau_pkg::sq_t i);
    vau_pkg::sq_t            o;
    logic [vau_pkg::REM_W-1:0] r4;
    logic [vau_pkg::REM_W-1:0] trial;
    o     = i;
    r4    = {i.rem[vau_pkg::REM_W-3:0], i.n[63:62]};
    trial = {{(vau_pkg::REM_W - 34){1'b0}}, i.root, 2'b01};
    o.n   = {i.n[61:0], 2'b00};
    if (r4 >= trial) begin
      o.rem  = r4 - trial;
      o.root = {i.root[30:0], 1'b1};
    end else begin
      o.rem  = r4;
      o.root = {i.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic vau_pkg::dv_t dv_step(input vau_pkg::dv_t i);
    vau_pkg::dv_t o;
    logic [32:0]  r2x;
    logic [32:0]  r2y;
    o   = i;
    r2x = {i.remx, i.dx[vau_pkg::DW-1]};
    r2y = {i.remy, i.dy[vau_pkg::DW-1]};
    // Quotient bits enter at the bottom as the dividend leaves at the top.
    if (r2x >= {1'b0, i.dvs}) begin
      o.remx = 32'(r2x - {1'b0, i.dvs});
      o.dx   = {i.dx[vau_pkg::DW-2:0], 1'b1};
    end else begin
      o.remx = r2x[31:0];
      o.dx   = {i.dx[vau_pkg::DW-2:0], 1'b0};
    end
    if (r2y >= {1'b0, i.dvs}) begin
      o.remy = 32'(r2y - {1'b0, i.dvs});
      o.dy   = {i.dy[vau_pkg::DW-2:0], 1'b1};
    end else begin
      o.remy = r2y[31:0];
      o.dy   = {i.dy[vau_pkg::DW-2:0], 1'b0};
    end
    return o;
  endfunction

  // Stage 1: operand select, products and exact add/subtract/negate.
  always_comb begin
    logic signed [31:0] mbx;
    logic signed [31:0] mby;
    mbx = in_b_x;
    mby = in_b_y;
    if (in_func == vau_pkg::FN_SCALE) begin
      mbx = in_scalar_in;
      mby = in_scalar_in;
    end else if (in_func == vau_pkg::FN_MAG || in_func == vau_pkg::FN_NORM) begin
      mbx = in_a_x;
      mby = in_a_y;
    end
    s1_nxt          = '0;
    s1_nxt.c.func   = in_func;
    s1_nxt.px       = 64'(in_a_x) * 64'(mbx);
    s1_nxt.py       = 64'(in_a_y) * 64'(mby);
    s1_nxt.c.ax_neg = in_a_x[31];
    s1_nxt.c.ay_neg = in_a_y[31];
    s1_nxt.c.s_neg  = in_scalar_in[31];
    s1_nxt.c.ax_mag = in_a_x[31] ? (~in_a_x + 32'd1) : in_a_x;
    s1_nxt.c.ay_mag = in_a_y[31] ? (~in_a_y + 32'd1) : in_a_y;
    s1_nxt.c.s_mag  = in_scalar_in[31] ? (~in_scalar_in + 32'd1) : in_scalar_in;
    case (in_func)
      vau_pkg::FN_ADD: begin
        s1_nxt.lx = 33'(in_a_x) + 33'(in_b_x);
        s1_nxt.ly = 33'(in_a_y) + 33'(in_b_y);
      end
      vau_pkg::FN_SUB: begin
        s1_nxt.lx = 33'(in_a_x) - 33'(in_b_x);
        s1_nxt.ly = 33'(in_a_y) - 33'(in_b_y);
      end
      vau_pkg::FN_NEG: begin
        s1_nxt.lx = -33'(in_a_x);
        s1_nxt.ly = -33'(in_a_y);
      end
      default: begin
        s1_nxt.lx = '0;
        s1_nxt.ly = '0;
      end
    endcase
  end

  // Stage 2: rounding, dot sum, saturation and the radicand.
  always_comb begin
    logic signed [65:0] tx;
    logic signed [65:0] ty;
    logic signed [65:0] td;
    vau_pkg::sat_t      sx;
    vau_pkg::sat_t      sy;
    vau_pkg::sat_t      ss;
    tx = 66'(s1_r.px) + vau_pkg::HALF;
    ty = 66'(s1_r.py) + vau_pkg::HALF;
    td = 66'(s1_r.px) + 66'(s1_r.py) + vau_pkg::HALF;
    sx = '0;
    sy = '0;
    ss = '0;
    case (s1_r.c.func)
      vau_pkg::FN_ADD, vau_pkg::FN_SUB, vau_pkg::FN_NEG: begin
        sx = vau_pkg::sat32(66'(s1_r.lx));
        sy = vau_pkg::sat32(66'(s1_r.ly));
      end
      vau_pkg::FN_SCALE, vau_pkg::FN_CMUL: begin
        sx = vau_pkg::sat32(tx >>> vau_pkg::FRAC_BITS);
        sy = vau_pkg::sat32(ty >>> vau_pkg::FRAC_BITS);
      end
      vau_pkg::FN_DOT: begin
        ss = vau_pkg::sat32(td >>> vau_pkg::FRAC_BITS);
      end
      default: begin
        sx = '0;
      end
    endcase
    s2_nxt      = '0;
    s2_nxt.c    = s1_r.c;
    s2_nxt.c.rx = sx.val;
    s2_nxt.c.ry = sy.val;
    s2_nxt.c.rs = ss.val;
    s2_nxt.c.st = (sx.hit || sy.hit || ss.hit) ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
    // Both products are squares here when a radicand is needed.
    s2_nxt.n    = $unsigned(s1_r.px) + $unsigned(s1_r.py);
  end

  // Divider entry: pick the divisor and settle magnitude and zero cases.
  always_comb begin
    vau_pkg::sq_t q;
    logic [31:0]  dvs;
    q        = sq_r[vau_pkg::SQ_STAGES-1];
    dvs      = (q.c.func == vau_pkg::FN_DIV) ? q.c.s_mag : q.root;
    dv_entry = '0;
    dv_entry.c    = q.c;
    dv_entry.dvs  = dvs;
    dv_entry.dx   = {q.c.ax_mag, {vau_pkg::FRAC_BITS{1'b0}}};
    dv_entry.dy   = {q.c.ay_mag, {vau_pkg::FRAC_BITS{1'b0}}};
    if (q.c.func == vau_pkg::FN_MAG) begin
      if (q.root[31]) begin
        dv_entry.c.rs = 32'h7FFF_FFFF;
        dv_entry.c.st = vau_pkg::ST_SAT;
      end else begin
        dv_entry.c.rs = q.root;
      end
    end else if ((q.c.func == vau_pkg::FN_DIV || q.c.func == vau_pkg::FN_NORM)
                 && dvs == 32'd0) begin
      dv_entry.c.st = vau_pkg::ST_ZERO;
    end
  end

  // Output: sign and saturate the quotients.
  always_comb begin
    vau_pkg::dv_t       d;
    logic               negx;
    logic               negy;
    logic signed [65:0] vx;
    logic signed [65:0] vy;
    vau_pkg::sat_t      sx;
    vau_pkg::sat_t      sy;
    d    = dv_r[vau_pkg::DW-1];
    negx = d.c.ax_neg ^ (d.c.func == vau_pkg::FN_DIV && d.c.s_neg);
    negy = d.c.ay_neg ^ (d.c.func == vau_pkg::FN_DIV && d.c.s_neg);
    vx   = negx ? -66'(d.dx) : 66'(d.dx);
    vy   = negy ? -66'(d.dy) : 66'(d.dy);
    sx   = vau_pkg::sat32(vx);
    sy   = vau_pkg::sat32(vy);
    ox_nxt  = d.c.rx;
    oy_nxt  = d.c.ry;
    os_nxt  = d.c.rs;
    ost_nxt = d.c.st;
    if ((d.c.func == vau_pkg::FN_DIV || d.c.func == vau_pkg::FN_NORM)
        && d.c.st != vau_pkg::ST_ZERO) begin
      ox_nxt  = sx.val;
      oy_nxt  = sy.val;
      ost_nxt = (sx.hit || sy.hit) ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      out_v_r <= dv_v_r[vau_pkg::DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      os_r  <= os_nxt;
      ost_r <= ost_nxt;
    end
  end

  for (genvar k = 0; k < vau_pkg::SQ_STAGES; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= (k == 0) ? s2_v_r : sq_v_r[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= sq_step((k == 0) ? s2_r : sq_r[(k == 0) ? 0 : k - 1]);
      end
    end
  end

  for (genvar k = 0; k < vau_pkg::DW; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= (k == 0) ? sq_v_r[vau_pkg::SQ_STAGES-1] : dv_v_r[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= dv_step((k == 0) ? dv_entry : dv_r[(k == 0) ? 0 : k - 1]);
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_result_x      = ox_r;
  assign out_result_y      = oy_r;
  assign out_result_scalar = os_r;
  assign out_status        = ost_r;

endmodule

`default_nettype wire
